/* hdl/vfc_pkg.sv */
package vfc_pkg;

  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned IDX_W      = 3;

  // object kind codes
  localparam logic [1:0] FUNC_POINT  = 2'd0;
  localparam logic [1:0] FUNC_SPHERE = 2'd1;
  localparam logic [1:0] FUNC_BOX    = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // plane register indexes
  localparam logic [IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_TOP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOTTOM = 3'd3;
  localparam logic [IDX_W-1:0] REG_NEAR   = 3'd4;
  localparam logic [IDX_W-1:0] REG_FAR    = 3'd5;

  typedef struct packed {
    logic signed [21:0] d;
    logic signed [13:0] nz;
    logic signed [13:0] ny;
    logic signed [13:0] nx;
  } plane_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [14:0]        ext_x;
    logic [14:0]        ext_y;
    logic [14:0]        ext_z;
    logic               culled;
  } item_t;

endpackage

/* hdl/view_frustum_cull_test.sv */
// Six-plane view frustum cull. One object (point, sphere or box) is taken per
// clock unless stalled; it runs through a chain of six plane cells, each two
// register stages deep (multiply, then sum and sign test), and an output
// register, sustaining one object per cycle while the output is drained.
// Backpressure on the result side stalls the chain only when a finished
// result is waiting at its end. Planes are written over the APB port at byte
// address 8*i (left, right, top, bottom, near, far) and reset to zero, which
// makes every object visible.
module view_frustum_cull_test import vfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[15:0], pos_y[31:16], pos_z[47:32], ext_x[62:48], ext_y[77:63],
  // ext_z[92:78], zero[95:93]
  input  logic [95:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // visible[0], zero[7:1]
  output logic [7:0]  m_axis_tdata
);

  plane_t planes [NUM_PLANES];
  logic   valid_c [NUM_PLANES+1];
  item_t  item_c  [NUM_PLANES+1];
  logic   en;
  logic   out_valid_q;
  logic   visible_q;

  vfc_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .planes_o (planes)
  );

  // stall only when a result at the chain end cannot move to the output
  assign en            = m_axis_tready || !out_valid_q || !valid_c[NUM_PLANES];
  assign s_axis_tready = en;

  assign valid_c[0]       = s_axis_tvalid;
  assign item_c[0].func   = s_axis_tuser;
  assign item_c[0].pos_x  = $signed(s_axis_tdata[15:0]);
  assign item_c[0].pos_y  = $signed(s_axis_tdata[31:16]);
  assign item_c[0].pos_z  = $signed(s_axis_tdata[47:32]);
  assign item_c[0].ext_x  = s_axis_tdata[62:48];
  assign item_c[0].ext_y  = s_axis_tdata[77:63];
  assign item_c[0].ext_z  = s_axis_tdata[92:78];
  assign item_c[0].culled = 1'b0;

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
    vfc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .plane_i (planes[g]),
      .valid_i (valid_c[g]),
      .item_i  (item_c[g]),
      .valid_o (valid_c[g+1]),
      .item_o  (item_c[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && valid_c[NUM_PLANES]) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_c[NUM_PLANES]) begin
      visible_q <= !item_c[NUM_PLANES].culled;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, visible_q};

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> (out_valid_q && !m_axis_tready && valid_c[NUM_PLANES]))
    else $error("chain stalled without a blocked result");

  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && valid_c[NUM_PLANES]) |=> out_valid_q)
    else $error("finished result not moved to output");

  a_hold_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> valid_c[NUM_PLANES] && $stable(item_c[NUM_PLANES].culled))
    else $error("result at chain end lost during stall");

endmodule

/* hdl/vfc_regs.sv */
module vfc_regs import vfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output plane_t      planes_o [NUM_PLANES]
);

  plane_t          planes_q [NUM_PLANES];
  logic [IDX_W-1:0] idx;
  logic            wr_en;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes_q[i] <= '0;
      end
    end else if (wr_en) begin
      case (idx)
        REG_LEFT:   planes_q[0] <= plane_t'(pwdata);
        REG_RIGHT:  planes_q[1] <= plane_t'(pwdata);
        REG_TOP:    planes_q[2] <= plane_t'(pwdata);
        REG_BOTTOM: planes_q[3] <= plane_t'(pwdata);
        REG_NEAR:   planes_q[4] <= plane_t'(pwdata);
        REG_FAR:    planes_q[5] <= plane_t'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEFT:   prdata = planes_q[0];
      REG_RIGHT:  prdata = planes_q[1];
      REG_TOP:    prdata = planes_q[2];
      REG_BOTTOM: prdata = planes_q[3];
      REG_NEAR:   prdata = planes_q[4];
      REG_FAR:    prdata = planes_q[5];
      default:    prdata = '0;
    endcase
  end

  assign planes_o = planes_q;

endmodule

/* hdl/vfc_cell.sv */
module vfc_cell import vfc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  plane_t plane_i,
  input  logic   valid_i,
  input  item_t  item_i,
  output logic   valid_o,
  output item_t  item_o
);

  logic signed [16:0] cx, cy, cz;
  logic signed [16:0] ex, ey, ez;
  logic signed [22:0] off_d;
  logic signed [30:0] prod_x_d, prod_y_d, prod_z_d;
  logic signed [30:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [22:0] off_q;
  logic               v1_q, v2_q;
  item_t              item1_q, item2_q, item2_d;
  logic signed [35:0] plane_dist;
  logic               is_box;

  assign ex     = $signed({2'b00, item_i.ext_x});
  assign ey     = $signed({2'b00, item_i.ext_y});
  assign ez     = $signed({2'b00, item_i.ext_z});
  assign is_box = (item_i.func == FUNC_BOX);

  // box: take the corner farthest along the normal, per axis
  always_comb begin
    cx = 17'(item_i.pos_x);
    cy = 17'(item_i.pos_y);
    cz = 17'(item_i.pos_z);
    if (is_box) begin
      cx = plane_i.nx[13] ? cx - ex : cx + ex;
      cy = plane_i.ny[13] ? cy - ey : cy + ey;
      cz = plane_i.nz[13] ? cz - ez : cz + ez;
    end
    // sphere: dist < -r becomes dist + r < 0
    off_d = 23'(plane_i.d);
    if (item_i.func == FUNC_SPHERE) begin
      off_d = off_d + 23'(ex);
    end
    prod_x_d = 31'(cx) * 31'(plane_i.nx);
    prod_y_d = 31'(cy) * 31'(plane_i.ny);
    prod_z_d = 31'(cz) * 31'(plane_i.nz);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
      off_q    <= off_d;
      item1_q  <= item_i;
      item2_q  <= item2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    plane_dist = 36'(prod_x_q) + 36'(prod_y_q) + 36'(prod_z_q)
               + 36'($signed({off_q, 12'b0}));
    item2_d = item1_q;
    if (item1_q.func != FUNC_NONE && plane_dist[35]) begin
      item2_d.culled = 1'b1;
    end
  end

  assign valid_o = v2_q;
  assign item_o  = item2_q;

endmodule
